// ===== design/sed_pkg.sv =====
// Shared types and constants of the string escape decoder.
package sed_pkg;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_EOF_LIT = 3'd0,
        ERR_EOF_ESC = 3'd1,
        ERR_BAD_OCT = 3'd2,
        ERR_BAD_DEC = 3'd3,
        ERR_BAD_HEX = 3'd4
    } err_t;

    // Result of decoding one figure against the current radix.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } figure_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_D   = 8'h64;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    localparam int DATA_OUT_W = 16;

endpackage

// ===== design/sed_figure.sv =====
// Figure decoder: maps a character to its figure value and checks it against the radix.
module sed_figure (
    input  logic [7:0]      char_in,
    input  sed_pkg::radix_t radix_sel,
    output sed_pkg::figure_t figure
);

    logic [5:0] raw_value;
    logic       is_figure;
    logic [4:0] base;

    always_comb
    begin
        is_figure = 1'b1;
        raw_value = 6'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            raw_value = 6'(char_in - 8'h30);
        end
        else if (char_in >= 8'h61 && char_in <= 8'h7A)
        begin
            raw_value = 6'(char_in - 8'h61 + 8'd10);
        end
        else if (char_in >= 8'h41 && char_in <= 8'h5A)
        begin
            raw_value = 6'(char_in - 8'h41 + 8'd10);
        end
        else
        begin
            is_figure = 1'b0;
        end

        unique case (radix_sel)
            sed_pkg::RADIX_OCT: base = 5'd8;
            sed_pkg::RADIX_DEC: base = 5'd10;
            default:            base = 5'd16;
        endcase

        figure.ok    = is_figure && (raw_value < {1'b0, base});
        figure.value = raw_value[3:0];
    end

endmodule

// ===== design/string_escape_decoder.sv =====
// Top level of the string escape decoder: input register, decode logic, result register.
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | one raw byte of the literal body
//  output  | m_tvalid m_tready m_tdata m_tuser | decoded byte, end of literal or error
//
// Each transfer is decoded while it sits in the input register; its result lands in the
// output register when the decoder advances. One transfer can be accepted every cycle
// while the output is not stalled. Escape starters and figures that give no result only
// update the decoder state. Reset returns the decoder to the literal body. A stalled
// output holds its result; a byte in the input register then waits too, even one that
// gives no result, and the input stops once that register is full.
module string_escape_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    typedef enum logic [1:0] {
        PH_BODY = 2'd0,
        PH_ESC  = 2'd1,
        PH_FIG  = 2'd2
    } phase_t;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_eoi_reg;

    phase_t           phase_reg, phase_next;
    sed_pkg::radix_t  radix_reg, radix_next;
    logic [1:0]       figs_reg, figs_next;
    logic [8:0]       accum_reg, accum_next;

    logic             out_valid_reg;
    sed_pkg::kind_t   out_kind_reg;
    logic [7:0]       out_byte_reg;
    sed_pkg::err_t    out_err_reg;

    logic             res_valid;
    sed_pkg::kind_t   res_kind;
    logic [7:0]       res_byte;
    sed_pkg::err_t    res_err;
    sed_pkg::err_t    fig_err;
    logic [8:0]       accum_scaled;
    sed_pkg::figure_t figure;
    logic             advance;

    sed_figure u_figure (
        .char_in   (in_char_reg),
        .radix_sel (radix_reg),
        .figure    (figure)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        figs_next  = figs_reg;
        accum_next = accum_reg;
        res_valid  = 1'b0;
        res_kind   = sed_pkg::KIND_BYTE;
        res_byte   = 8'd0;
        res_err    = sed_pkg::ERR_EOF_LIT;

        unique case (radix_reg)
            sed_pkg::RADIX_OCT:
            begin
                fig_err      = sed_pkg::ERR_BAD_OCT;
                accum_scaled = {accum_reg[5:0], 3'b000};
            end
            sed_pkg::RADIX_DEC:
            begin
                fig_err      = sed_pkg::ERR_BAD_DEC;
                accum_scaled = 9'({accum_reg[5:0], 3'b000} + {accum_reg[7:0], 1'b0});
            end
            default:
            begin
                fig_err      = sed_pkg::ERR_BAD_HEX;
                accum_scaled = {accum_reg[4:0], 4'b0000};
            end
        endcase

        unique case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_BODY;
                if (in_eoi_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = sed_pkg::KIND_ERR;
                    res_err   = sed_pkg::ERR_EOF_ESC;
                end
                else
                begin
                    unique case (in_char_reg)
                        sed_pkg::CH_ZERO:
                        begin
                            radix_next = sed_pkg::RADIX_OCT;
                            figs_next  = 2'd3;
                            accum_next = 9'd0;
                            phase_next = PH_FIG;
                        end
                        sed_pkg::CH_LOWER_D:
                        begin
                            radix_next = sed_pkg::RADIX_DEC;
                            figs_next  = 2'd2;
                            accum_next = 9'd0;
                            phase_next = PH_FIG;
                        end
                        sed_pkg::CH_LOWER_X:
                        begin
                            radix_next = sed_pkg::RADIX_HEX;
                            figs_next  = 2'd2;
                            accum_next = 9'd0;
                            phase_next = PH_FIG;
                        end
                        8'h61:   begin res_valid = 1'b1; res_byte = 8'd7;  end // a
                        8'h62:   begin res_valid = 1'b1; res_byte = 8'd8;  end // b
                        8'h63:   begin res_valid = 1'b1; res_byte = 8'd0;  end // c
                        8'h66:   begin res_valid = 1'b1; res_byte = 8'd12; end // f
                        8'h6E:   begin res_valid = 1'b1; res_byte = 8'd10; end // n
                        8'h72:   begin res_valid = 1'b1; res_byte = 8'd13; end // r
                        8'h74:   begin res_valid = 1'b1; res_byte = 8'd9;  end // t
                        8'h76:   begin res_valid = 1'b1; res_byte = 8'd11; end // v
                        default: begin res_valid = 1'b1; res_byte = in_char_reg; end
                    endcase
                end
            end
            PH_FIG:
            begin
                if (in_eoi_reg || !figure.ok)
                begin
                    phase_next = PH_BODY;
                    res_valid  = 1'b1;
                    res_kind   = sed_pkg::KIND_ERR;
                    res_err    = fig_err;
                end
                else
                begin
                    accum_next = 9'(accum_scaled + {5'd0, figure.value});
                    figs_next  = 2'(figs_reg - 2'd1);
                    if (figs_reg == 2'd1)
                    begin
                        phase_next = PH_BODY;
                        res_valid  = 1'b1;
                        res_byte   = accum_next[7:0];
                    end
                end
            end
            default:
            begin
                phase_next = PH_BODY;
                if (in_eoi_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = sed_pkg::KIND_ERR;
                    res_err   = sed_pkg::ERR_EOF_LIT;
                end
                else if (in_char_reg == sed_pkg::CH_QUOTE)
                begin
                    res_valid = 1'b1;
                    res_kind  = sed_pkg::KIND_END;
                end
                else if (in_char_reg == sed_pkg::CH_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_byte  = in_char_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_BODY;
            radix_reg     <= sed_pkg::RADIX_OCT;
            figs_reg      <= 2'd0;
            accum_reg     <= 9'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                figs_reg  <= figs_next;
                accum_reg <= accum_next;
            end

            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tuser[0];
        end
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_err_reg  <= res_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(sed_pkg::DATA_OUT_W - 11)'(0), out_err_reg, out_byte_reg};

endmodule

// ===== design/sed_checker.sv =====
// Port-level checker for the string escape decoder, bound to the top level.
module sed_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == sed_pkg::KIND_BYTE || m_tuser == sed_pkg::KIND_END
                     || m_tuser == sed_pkg::KIND_ERR)
        else $error("unknown result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sed_pkg::KIND_END |-> m_tdata == 16'd0)
        else $error("end of literal carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sed_pkg::KIND_ERR
            |-> m_tdata[7:0] == 8'd0 && m_tdata[10:8] <= 3'd4 && m_tdata[15:11] == 5'd0)
        else $error("malformed error result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sed_pkg::KIND_BYTE |-> m_tdata[15:8] == 8'd0)
        else $error("decoded byte carries an error code");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
